// ----- src/svu_pkg.sv -----
// Shared types, constants and the 2^(-i/256) table of the softmax vector unit.
// No dependencies.
package svu_pkg;

   localparam int MAX_LENGTH = 64;
   localparam int ADDR_W = $clog2(MAX_LENGTH);
   localparam int CNT_W = $clog2(MAX_LENGTH + 1);
   localparam int SUM_W = 23;
   localparam int EXP_W = 17;
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;
   localparam logic [63:0] STEP_Q32 = 64'd4283353945;

   typedef struct packed {
      logic signed [15:0] score;
      logic final_score;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic final_probability;
   } rsp_type;

   typedef logic [32:0] pow_tab_type [256];

   function automatic pow_tab_type build_pow_tab();
      pow_tab_type tab;
      logic [63:0] t;
      t = 64'd1 << 32;
      for (int i = 0; i < 256; i++) begin
         tab[i] = t[32:0];
         t = (t * STEP_Q32 + (64'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage

// ----- src/softmax_vector_unit_top.sv -----
// Softmax vector unit top level: score and exponent memories, pass sequencer.
// Depends on svu_pkg, svu_exp and svu_div.
//
// Scores, signed Q7.8, arrive one request per cycle unless stalled and go to
// a 64-entry score memory while the running maximum is kept; up to MAX_LENGTH
// scores are stored and any further ones are dropped. The request that carries
// final_score closes the vector; from then on req_stall stays high until the
// last probability of the vector has been handed to the output register. The
// exponent pass streams the score memory through the two-stage exponential
// unit at one element per cycle. The divide pass then handles each element
// in turn: a memory read, a start, and the bit-serial divider that produces
// 17 quotient bits and hands over its result once the output register is
// free. The output register lets the next division run while a result waits.
module softmax_vector_unit_top
   import svu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_EXP    = 3'd1;
   localparam logic [2:0] ST_DREAD  = 3'd2;
   localparam logic [2:0] ST_DSTART = 3'd3;
   localparam logic [2:0] ST_DWAIT  = 3'd4;

   logic [15:0]       score_mem [MAX_LENGTH];
   logic [EXP_W-1:0]  exp_mem [MAX_LENGTH];

   logic [2:0]        state_ff, state_in;
   logic signed [15:0] max_ff, max_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic [CNT_W-1:0]  didx_ff, didx_in;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic signed [15:0] score_rd_ff;
   logic [EXP_W-1:0]  exp_rd_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              req_fire;
   logic              store_en;
   logic              rd_en;
   logic [16:0]       diff;
   logic              e_valid;
   logic [EXP_W-1:0]  e_val;
   logic [ADDR_W-1:0] e_addr;
   logic              div_start;
   logic              div_ack;
   logic              div_done;
   logic [16:0]       div_q;
   logic [32:0]       numer;
   logic              out_free;
   logic              last_div;

   assign req_stall = (state_ff != ST_LOAD);
   assign req_fire = req_valid && !req_stall;
   assign store_en = req_fire && (count_ff < CNT_W'(MAX_LENGTH));
   assign rd_en = (state_ff == ST_EXP) && (issue_ff < count_ff);
   assign diff = {max_ff[15], max_ff} - {score_rd_ff[15], score_rd_ff};
   assign numer = {exp_rd_ff, 16'd0} + 33'(sum_ff[SUM_W-1:1]);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_div = (didx_ff == count_ff - CNT_W'(1));
   assign div_start = (state_ff == ST_DSTART);
   assign div_ack = (state_ff == ST_DWAIT) && div_done && out_free;

   svu_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_y      (diff[15:0]),
      .in_addr   (rd_addr_ff),
      .out_valid (e_valid),
      .out_e     (e_val),
      .out_addr  (e_addr)
   );

   svu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (sum_ff),
      .ack      (div_ack),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      max_in = max_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      issue_in = issue_ff;
      didx_in = didx_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_LOAD: begin
            if (store_en) begin
               if (req_data.score > max_ff) begin
                  max_in = req_data.score;
               end
               count_in = count_ff + CNT_W'(1);
            end
            if (req_fire && req_data.final_score) begin
               state_in = ST_EXP;
               issue_in = '0;
               sum_in = '0;
            end
         end
         ST_EXP: begin
            if (rd_en) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (e_valid) begin
               sum_in = sum_ff + SUM_W'(e_val);
               if (CNT_W'(e_addr) == count_ff - CNT_W'(1)) begin
                  state_in = ST_DREAD;
                  didx_in = '0;
               end
            end
         end
         ST_DREAD: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_ack) begin
               // Saturate 1.0 to the largest Q0.16 code.
               rsp_in.probability = div_q[16] ? 16'hFFFF : div_q[15:0];
               rsp_in.final_probability = last_div;
               rsp_valid_in = 1'b1;
               if (last_div) begin
                  state_in = ST_LOAD;
                  max_in = 16'sh8000;
                  count_in = '0;
                  sum_in = '0;
               end else begin
                  didx_in = didx_ff + CNT_W'(1);
                  state_in = ST_DREAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         max_ff <= 16'sh8000;
         count_ff <= '0;
         sum_ff <= '0;
         issue_ff <= '0;
         didx_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_ff <= max_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         issue_ff <= issue_in;
         didx_ff <= didx_in;
         rd_valid_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      rd_addr_ff <= issue_ff[ADDR_W-1:0];
   end

   // Score memory: written while loading, read during the exponent pass.
   always_ff @(posedge clock) begin
      if (store_en) begin
         score_mem[count_ff[ADDR_W-1:0]] <= req_data.score;
      end
      score_rd_ff <= score_mem[issue_ff[ADDR_W-1:0]];
   end

   // Exponent memory: written by the exponential unit, read by the divide pass.
   always_ff @(posedge clock) begin
      if (e_valid) begin
         exp_mem[e_addr] <= e_val;
      end
      exp_rd_ff <= exp_mem[didx_ff[ADDR_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_sum_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> sum_ff != '0)
      else $error("division started with a zero sum");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LENGTH))
      else $error("element count beyond the store depth");

   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      div_done && !div_ack && !div_start |=> div_done)
      else $error("divider result lost before it was taken");

   a_exp_in_pass: assert property (@(posedge clock) disable iff (reset)
      e_valid |-> state_ff == ST_EXP)
      else $error("exponent written outside the exponent pass");

endmodule

// ----- src/svu_exp.sv -----
// Two-stage exponential unit: e = 2^(-y*log2(e)) in Q1.16 for y in Q8.
// Depends on svu_pkg for the power table.
module svu_exp
   import svu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [15:0]       in_y,
   input  logic [ADDR_W-1:0] in_addr,
   output logic              out_valid,
   output logic [EXP_W-1:0]  out_e,
   output logic [ADDR_W-1:0] out_addr
);

   logic              v1_ff;
   logic [16:0]       w_ff;
   logic [ADDR_W-1:0] a1_ff;
   logic              v2_ff;
   logic [EXP_W-1:0]  e_ff;
   logic [ADDR_W-1:0] a2_ff;
   logic [32:0]       prod;
   logic [8:0]        k;
   logic [33:0]       rnd_sum;
   logic [33:0]       shifted;
   logic [EXP_W-1:0]  e_in;

   assign prod = 33'(in_y) * 33'(LOG2E_Q16) + 33'd32768;
   assign k = w_ff[16:8];

   always_comb begin
      rnd_sum = {1'b0, POW_TAB[w_ff[7:0]]} + (34'd1 << (6'd15 + {1'b0, k[4:0]}));
      shifted = rnd_sum >> (6'd16 + {1'b0, k[4:0]});
      // Beyond k = 17 the value rounds to zero.
      if (k > 9'd17) begin
         e_in = '0;
      end else begin
         e_in = shifted[EXP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      w_ff  <= prod[32:16];
      a1_ff <= in_addr;
      e_ff  <= e_in;
      a2_ff <= a1_ff;
   end

   assign out_valid = v2_ff;
   assign out_e = e_ff;
   assign out_addr = a2_ff;

endmodule

// ----- src/svu_div.sv -----
// Restoring divider, one quotient bit per cycle, for the probability pass.
// Depends on svu_pkg for widths.
module svu_div
   import svu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [32:0]      numer,
   input  logic [SUM_W-1:0] denom,
   input  logic             ack,
   output logic             done,
   output logic [16:0]      quotient
);

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [16:0]      quo_ff, quo_in;
   logic [SUM_W-1:0] den_ff;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SUM_W:0]   trial;

   assign trial = {rem_ff, quo_ff[16]};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff && !ack;
      if (start) begin
         // The quotient fits 17 bits, so the upper numerator bits start below denom.
         rem_in  = SUM_W'(numer[32:17]);
         quo_in  = numer[16:0];
         cnt_in  = 5'd17;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = SUM_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[15:0], 1'b1};
         end else begin
            rem_in = trial[SUM_W-1:0];
            quo_in = {quo_ff[15:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= denom;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- bench/softmax_vector_unit_top_tb.sv -----
// Testbench of the softmax vector unit: scores in, probabilities out, scored against a
// fixed-point softmax predictor. Depends on svu_pkg and softmax_vector_unit_top.
`timescale 1ns / 100ps

class softmax_scoreboard;
   logic [63:0] pow2_frac [256];
   logic [15:0] stored_scores [64];
   int          stored_count;
   logic signed [15:0] vector_max;
   svu_pkg::rsp_type expected_probs [$];
   int mismatches;

   function new();
      logic [63:0] t;
      t = 64'd1 << 32;
      for (int i = 0; i < 256; i++) begin
         pow2_frac[i] = t;
         t = (t * 64'd4283353945 + (64'd1 << 31)) >> 32;
      end
      stored_count = 0;
      vector_max = -16'sd32768;
      mismatches = 0;
   endfunction

   // exp(-y) for y >= 0 in Q8, result in Q1.16.
   function logic [16:0] exp_of_neg(logic [16:0] y);
      logic [63:0] w;
      logic [63:0] k;
      int sh;
      w = (64'(y) * 64'd94548 + 64'd32768) >> 16;
      k = w >> 8;
      if (k > 17) return 17'd0;
      sh = 16 + int'(k);
      return 17'((pow2_frac[w[7:0]] + (64'd1 << (sh - 1))) >> sh);
   endfunction

   // Notes one accepted request; a final score produces the whole vector's results.
   function void note_request(svu_pkg::req_type r);
      logic [16:0] e [64];
      logic [63:0] sum;
      logic [63:0] p;
      svu_pkg::rsp_type x;
      if (stored_count < 64) begin
         stored_scores[stored_count] = r.score;
         if (r.score > vector_max) vector_max = r.score;
         stored_count++;
      end
      if (!r.final_score) return;
      sum = 0;
      for (int i = 0; i < stored_count; i++) begin
         e[i] = exp_of_neg(17'(int'(vector_max) - int'($signed(stored_scores[i]))));
         sum += 64'(e[i]);
      end
      for (int i = 0; i < stored_count; i++) begin
         p = (64'(e[i]) * 64'd65536 + (sum >> 1)) / sum;
         if (p > 64'd65535) p = 64'd65535;
         x.probability = p[15:0];
         x.final_probability = (i + 1 == stored_count);
         expected_probs.push_back(x);
      end
      stored_count = 0;
      vector_max = -16'sd32768;
   endfunction

   function void check_result(svu_pkg::rsp_type a);
      svu_pkg::rsp_type x;
      if (expected_probs.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", a);
         return;
      end
      x = expected_probs.pop_front();
      if (x.probability !== a.probability || x.final_probability !== a.final_probability) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected p=%0d last=%0d, got p=%0d last=%0d",
                     x.probability, x.final_probability, a.probability,
                     a.final_probability);
      end
   endfunction
endclass

module softmax_vector_unit_top_tb;
   import svu_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   softmax_scoreboard board;
   // Percent of cycles in which sender and receiver idle during the current phase.
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;

   softmax_vector_unit_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random; results are checked on acceptance.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   // Offers one request, with random idle gaps, and holds it until accepted.
   // The request is noted in the scoreboard at the edge where it is taken.
   // Valid stays high after acceptance unless the next call idles or the
   // stimulus ends.
   task automatic send_score(logic signed [15:0] s, logic fin);
      req_type r;
      r.score = s;
      r.final_score = fin;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   // Sends one vector of the given length; the score spread decides how many
   // elements land in the very small exponent region.
   task automatic send_vector(int len, int spread);
      logic signed [15:0] base;
      logic signed [15:0] s;
      int v;
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
         if (spread >= 65535) s = 16'($urandom);
         else begin
            v = int'(base) + $signed($urandom_range(spread)) - spread / 2;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            s = v[15:0];
         end
         send_score(s, i == len - 1);
      end
   endtask

   initial begin
      int len;
      int spreads [4];
      board = new();
      spreads = '{64, 1024, 8192, 65535};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a single element saturates to full scale.
      send_score(16'sd0, 1'b1);
      send_score(-16'sd32768, 1'b1);
      // Both extremes in one vector; the smaller gets a zero exponent.
      send_score(16'sd32767, 1'b0);
      send_score(-16'sd32768, 1'b1);
      // Equal scores split evenly, with a close neighbor.
      send_score(16'sd256, 1'b0);
      send_score(16'sd256, 1'b0);
      send_score(16'sd255, 1'b1);
      // An exponent near the cutoff: a gap of about 12.5 in Q8.
      send_score(16'sd3200, 1'b0);
      send_score(16'sd0, 1'b0);
      send_score(-16'sd1, 1'b1);
      // Store full: the scores past the 64th are dropped, even a large one,
      // and the final one closes the vector.
      for (int i = 0; i < 64; i++) send_score(16'(i * 16), 1'b0);
      send_score(16'sd32767, 1'b0);
      send_score(-16'sd5, 1'b1);

      // Random vectors under three idling regimes.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct   = (ph == 0) ? 31 : (ph == 1) ? 60 : 0;
         receiver_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 31 : 0;
         for (int n = 0; n < 140; ) begin
            // Mostly short vectors; now and then a full or overfull one.
            case ($urandom_range(9))
               0:       len = $urandom_range(64, 68);
               1, 2:    len = 1;
               default: len = $urandom_range(2, 8);
            endcase
            send_vector(len, spreads[$urandom_range(3)]);
            n += len;
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected probability, then let the block settle.
      while (board.expected_probs.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // The limit covers the whole run, with stalls, several times over.
   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ----- softmax_vector_unit_top.f -----
src/svu_pkg.sv
src/svu_exp.sv
src/svu_div.sv
src/softmax_vector_unit_top.sv
bench/softmax_vector_unit_top_tb.sv
